>>> rtl/ftlm_pkg.sv
// Shared types and constants for the force/torque limit monitor.
// Depends on nothing; every other file of the block refers to it by scoped names.
package ftlm_pkg;

	localparam int LIMIT_BITS       = 15;
	localparam int REG_COUNT        = 8;
	localparam int REG_IDX_BITS     = 3;
	localparam int AXIS_COUNT       = 6;
	localparam int SAMPLE_BITS_DEF  = 16;
	localparam int TIMER_BITS_DEF   = 24;

	// Limit register indexes
	localparam logic [REG_IDX_BITS-1:0] REG_FORCE_NORM  = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_TORQUE_NORM = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_FORCE_X     = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_FORCE_Y     = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_FORCE_Z     = 3'd4;
	localparam logic [REG_IDX_BITS-1:0] REG_TORQUE_X    = 3'd5;
	localparam logic [REG_IDX_BITS-1:0] REG_TORQUE_Y    = 3'd6;
	localparam logic [REG_IDX_BITS-1:0] REG_TORQUE_Z    = 3'd7;

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_TICK   = 2'd1,
		OP_START  = 2'd2,
		OP_STOP   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_RUN       = 2'd0,
		ST_VIOLATION = 2'd1,
		ST_TIMEOUT   = 2'd2,
		ST_STOP      = 2'd3
	} status_t;

	typedef struct packed {
		op_t  op;
		logic violation;
	} cmd_t;

	typedef struct packed {
		status_t status;
		logic    armed;
	} result_t;

endpackage

>>> rtl/ftlm_lane.sv
// One sensor axis: magnitude, square and per-axis limit check.
// Depends on ftlm_pkg for the limit width.
module ftlm_lane #(
	parameter int SAMPLE_BITS = ftlm_pkg::SAMPLE_BITS_DEF
) (
	input  logic signed [SAMPLE_BITS-1:0]      sample,
	input  logic [ftlm_pkg::LIMIT_BITS-1:0]    axis_limit,
	output logic [2*SAMPLE_BITS-1:0]           square,
	output logic                               over
);

	localparam int CMP_W = (SAMPLE_BITS > ftlm_pkg::LIMIT_BITS) ?
		SAMPLE_BITS : ftlm_pkg::LIMIT_BITS;

	logic [SAMPLE_BITS-1:0] mag;

	// Most negative value maps to 2^(SAMPLE_BITS-1), which still fits unsigned
	assign mag    = sample[SAMPLE_BITS-1] ? (~sample + SAMPLE_BITS'(1)) : sample;
	assign square = (2*SAMPLE_BITS)'(mag) * (2*SAMPLE_BITS)'(mag);
	assign over   = (axis_limit != '0) && (CMP_W'(mag) > CMP_W'(axis_limit));

endmodule

>>> rtl/ftlm_ctrl.sv
// Monitor state: armed flag, latched status and tick countdown.
// Depends on ftlm_pkg for op, status, command and result types.
module ftlm_ctrl #(
	parameter int TIMER_BITS = ftlm_pkg::TIMER_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  ftlm_pkg::cmd_t          cmd,
	input  logic [TIMER_BITS-1:0]   timeout_ticks,
	output ftlm_pkg::result_t       result
);

	ftlm_pkg::status_t     status_q, status_d;
	logic                  active_q, active_d;
	logic                  timeout_en_q, timeout_en_d;
	logic [TIMER_BITS-1:0] ticks_left_q, ticks_left_d;

	always_comb begin
		status_d     = status_q;
		active_d     = active_q;
		timeout_en_d = timeout_en_q;
		ticks_left_d = ticks_left_q;
		case (cmd.op)
			ftlm_pkg::OP_START: begin
				active_d = 1'b1;
				status_d = ftlm_pkg::ST_RUN;
				if (timeout_ticks != '0) begin
					timeout_en_d = 1'b1;
					ticks_left_d = timeout_ticks;
				end else begin
					timeout_en_d = 1'b0;
				end
			end
			ftlm_pkg::OP_STOP: begin
				if (active_q) begin
					status_d = ftlm_pkg::ST_STOP;
					active_d = 1'b0;
				end
			end
			ftlm_pkg::OP_TICK: begin
				if (active_q && timeout_en_q) begin
					if (ticks_left_q == '0) begin
						status_d = ftlm_pkg::ST_TIMEOUT;
						active_d = 1'b0;
					end else begin
						ticks_left_d = ticks_left_q - TIMER_BITS'(1);
					end
				end
			end
			ftlm_pkg::OP_SAMPLE: begin
				if (active_q && cmd.violation) begin
					status_d = ftlm_pkg::ST_VIOLATION;
					active_d = 1'b0;
				end
			end
			default: begin
				status_d = status_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q     <= ftlm_pkg::ST_STOP;
			active_q     <= 1'b0;
			timeout_en_q <= 1'b0;
			ticks_left_q <= '0;
		end else if (step) begin
			status_q     <= status_d;
			active_q     <= active_d;
			timeout_en_q <= timeout_en_d;
			ticks_left_q <= ticks_left_d;
		end
	end

	assign result.status = status_d;
	assign result.armed  = active_d;

endmodule

>>> rtl/force_torque_limit_monitor.sv
// Top level of the force/torque limit monitor: handshakes, limit registers,
// three-stage pipeline. Depends on ftlm_pkg, ftlm_lane and ftlm_ctrl.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  input    | in_valid/in_stall  | op, force_x/y/z, torque_x/y/z, timeout_ticks
//  output   | out_valid/out_stall| status, armed
//  config   | cfg_we             | cfg_index, cfg_data
//
// One transaction is accepted per cycle when the output is not held back.
// The stages in order: input register, square/axis stage, then the norm
// compare and state update that load the result register.
// in_stall rises only when all three stages hold transactions and out_stall
// is high; a bubble in the pipeline still takes a new transaction.
// Reset clears the limits to zero (all checks off) and leaves the monitor
// disarmed with status stop requested.
module force_torque_limit_monitor #(
	parameter int SAMPLE_BITS = ftlm_pkg::SAMPLE_BITS_DEF,
	parameter int TIMER_BITS  = ftlm_pkg::TIMER_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          op,
	input  logic signed [SAMPLE_BITS-1:0]       force_x,
	input  logic signed [SAMPLE_BITS-1:0]       force_y,
	input  logic signed [SAMPLE_BITS-1:0]       force_z,
	input  logic signed [SAMPLE_BITS-1:0]       torque_x,
	input  logic signed [SAMPLE_BITS-1:0]       torque_y,
	input  logic signed [SAMPLE_BITS-1:0]       torque_z,
	input  logic [TIMER_BITS-1:0]               timeout_ticks,
	// output channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          status,
	output logic                                armed,
	// configuration
	input  logic                                cfg_we,
	input  logic [ftlm_pkg::REG_IDX_BITS-1:0]   cfg_index,
	input  logic [ftlm_pkg::LIMIT_BITS-1:0]     cfg_data
);

	localparam int SQ_W    = 2 * SAMPLE_BITS;
	localparam int LSQ_W   = 2 * ftlm_pkg::LIMIT_BITS;
	// Sum of three squares needs two extra bits
	localparam int NORM_W  = (SQ_W + 2 > LSQ_W) ? SQ_W + 2 : LSQ_W;

	// ---------------------------------------------------------------------
	// Limit registers; norm limits are also kept squared
	// ---------------------------------------------------------------------
	logic [ftlm_pkg::LIMIT_BITS-1:0] limit_q [ftlm_pkg::REG_COUNT];
	logic [LSQ_W-1:0]                force_lim_sq_q;
	logic [LSQ_W-1:0]                torque_lim_sq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ftlm_pkg::REG_COUNT; i++) begin
				limit_q[i] <= '0;
			end
		end else if (cfg_we) begin
			limit_q[cfg_index] <= cfg_data;
		end
	end

	// Square the norm limits in the cycle after the write; the user must keep the block idle then (not enforced here)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			force_lim_sq_q  <= '0;
			torque_lim_sq_q <= '0;
		end else begin
			force_lim_sq_q  <= LSQ_W'(limit_q[ftlm_pkg::REG_FORCE_NORM]) *
				LSQ_W'(limit_q[ftlm_pkg::REG_FORCE_NORM]);
			torque_lim_sq_q <= LSQ_W'(limit_q[ftlm_pkg::REG_TORQUE_NORM]) *
				LSQ_W'(limit_q[ftlm_pkg::REG_TORQUE_NORM]);
		end
	end

	// ---------------------------------------------------------------------
	// Flow control: each stage moves when it is empty or the next one moves
	// ---------------------------------------------------------------------
	logic v_s1, v_s2, out_valid_q;
	logic ready_s1, ready_s2, ready_out;
	logic accept, step;

	assign ready_out = !out_valid_q || !out_stall;
	assign ready_s2  = !v_s2 || ready_out;
	assign ready_s1  = !v_s1 || ready_s2;
	assign in_stall  = !ready_s1;
	assign accept    = in_valid && ready_s1;
	assign step      = v_s2 && ready_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ready_s1) begin
				v_s1 <= in_valid;
			end
			if (ready_s2) begin
				v_s2 <= v_s1;
			end
			if (ready_out) begin
				out_valid_q <= v_s2;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stage 1: capture the accepted transaction
	// ---------------------------------------------------------------------
	ftlm_pkg::op_t          op_s1;
	logic [SAMPLE_BITS-1:0] sample_s1 [ftlm_pkg::AXIS_COUNT];
	logic [TIMER_BITS-1:0]  timeout_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1        <= ftlm_pkg::op_t'(op);
			sample_s1[0] <= force_x;
			sample_s1[1] <= force_y;
			sample_s1[2] <= force_z;
			sample_s1[3] <= torque_x;
			sample_s1[4] <= torque_y;
			sample_s1[5] <= torque_z;
			timeout_s1   <= timeout_ticks;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 2: per-axis magnitude, square and axis limit check
	// ---------------------------------------------------------------------
	logic [SQ_W-1:0]                 sq     [ftlm_pkg::AXIS_COUNT];
	logic [ftlm_pkg::AXIS_COUNT-1:0] over;

	for (genvar g = 0; g < ftlm_pkg::AXIS_COUNT; g++) begin : g_lane
		ftlm_lane #(
			.SAMPLE_BITS(SAMPLE_BITS)
		) u_lane (
			.sample     (sample_s1[g]),
			.axis_limit (limit_q[int'(ftlm_pkg::REG_FORCE_X) + g]),
			.square     (sq[g]),
			.over       (over[g])
		);
	end

	ftlm_pkg::op_t         op_s2;
	logic [SQ_W-1:0]       sq_s2 [ftlm_pkg::AXIS_COUNT];
	logic                  axis_over_s2;
	logic [TIMER_BITS-1:0] timeout_s2;

	always_ff @(posedge clk) begin
		if (v_s1 && ready_s2) begin
			op_s2        <= op_s1;
			sq_s2        <= sq;
			axis_over_s2 <= |over;
			timeout_s2   <= timeout_s1;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 3: norm compare, state update, result register
	// ---------------------------------------------------------------------
	logic [NORM_W-1:0] force_sum, torque_sum;
	logic              force_over, torque_over;
	ftlm_pkg::cmd_t    cmd;
	ftlm_pkg::result_t result_d, result_q;

	assign force_sum  = NORM_W'(sq_s2[0]) + NORM_W'(sq_s2[1]) + NORM_W'(sq_s2[2]);
	assign torque_sum = NORM_W'(sq_s2[3]) + NORM_W'(sq_s2[4]) + NORM_W'(sq_s2[5]);

	// A zero norm limit turns its check off
	assign force_over  = (limit_q[ftlm_pkg::REG_FORCE_NORM] != '0) &&
		(force_sum > NORM_W'(force_lim_sq_q));
	assign torque_over = (limit_q[ftlm_pkg::REG_TORQUE_NORM] != '0) &&
		(torque_sum > NORM_W'(torque_lim_sq_q));

	assign cmd.op        = op_s2;
	assign cmd.violation = force_over || torque_over || axis_over_s2;

	ftlm_ctrl #(
		.TIMER_BITS(TIMER_BITS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.cmd           (cmd),
		.timeout_ticks (timeout_s2),
		.result        (result_d)
	);

	// Hold the result while the consumer stalls
	always_ff @(posedge clk) begin
		if (step) begin
			result_q <= result_d;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = logic'(result_q.status[1]) ? {1'b1, result_q.status[0]} :
		{1'b0, result_q.status[0]};
	assign armed     = result_q.armed;

endmodule

>>> rtl/ftlm_checker.sv
// Port-level checks for the force/torque limit monitor, bound to its top level.
// Depends on ftlm_pkg for the status codes.
module ftlm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] status,
	input logic       armed
);

	// Armed exactly while the status reads running
	a_armed_running: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (armed == (status == ftlm_pkg::ST_RUN)))
		else $error("armed flag disagrees with status");

	// With no result waiting the pipeline always has room
	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while output is empty");

	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result dropped while stalled");

	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(status) && $stable(armed)))
		else $error("result changed while stalled");

endmodule

bind force_torque_limit_monitor ftlm_checker u_ftlm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.status    (status),
	.armed     (armed)
);
